@@ hw/rtl/plpd_pkg.sv @@
package plpd_pkg;

    localparam int NUM_LISTS_DEF  = 16;
    localparam int MAX_POINTS_DEF = 32;

    localparam int LIST_SEL_W = 4;
    localparam int INDEX_W    = 5;
    localparam int COORD_W    = 16;
    localparam int TOL_W      = 15;
    localparam int COUNT_W    = 6;
    localparam int MASK_W     = 16;

    localparam logic [TOL_W-1:0] TOL_RESET = 15'd48;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_READ = 2'd2
    } t_status;

endpackage

@@ hw/rtl/plpd_bank.sv @@
// One list: point memory, count and delete compaction engine.
module plpd_bank
    import plpd_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start_del,
    input  logic                       i_app,
    input  logic [$clog2(MAX_POINTS)-1:0] i_rd_addr,
    input  logic signed [COORD_W-1:0]  i_x,
    input  logic signed [COORD_W-1:0]  i_y,
    input  logic [TOL_W-1:0]           i_tol,
    output logic [COORD_W-1:0]         o_rd_x,
    output logic [COORD_W-1:0]         o_rd_y,
    output logic [$clog2(MAX_POINTS+1)-1:0] o_count,
    output logic                       o_busy,
    output logic                       o_removed
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS+1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_SHIFT = 3'b100
    } t_bstate;

    logic [COORD_W-1:0] r_mem_x [MAX_POINTS];
    logic [COORD_W-1:0] r_mem_y [MAX_POINTS];

    t_bstate r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;     // address issued
    logic          r_pend, n_pend;   // read data valid for r_ptr-1
    logic          r_removed, n_removed;
    logic [COORD_W-1:0] r_dx, r_dy;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [COORD_W-1:0] wx, wy;
    logic          hit;
    logic signed [COORD_W+1:0] px, py, cx, cy, tl;

    assign px = {{2{r_dx[COORD_W-1]}}, r_dx};
    assign py = {{2{r_dy[COORD_W-1]}}, r_dy};
    assign cx = {{2{i_x[COORD_W-1]}}, i_x};
    assign cy = {{2{i_y[COORD_W-1]}}, i_y};
    assign tl = {3'b000, i_tol};
    assign hit = (cx <= px + tl) && (cx >= px - tl) && (cy <= py + tl) && (cy >= py - tl);

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem_x[waddr] <= wx;
            r_mem_y[waddr] <= wy;
        end
        r_dx <= r_mem_x[raddr];
        r_dy <= r_mem_y[raddr];
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_pend    = 1'b0;
        n_removed = r_removed;
        we        = 1'b0;
        waddr     = r_count[AW-1:0];
        wx        = i_x;
        wy        = i_y;
        raddr     = i_rd_addr;
        unique case (r_state)
            S_IDLE: begin
                if (i_app && r_count < CW'(MAX_POINTS)) begin
                    we      = 1'b1;
                    n_count = r_count + 1'b1;
                end
                if (i_start_del) begin
                    n_removed = 1'b0;
                    if (r_count != '0) begin
                        raddr   = '0;
                        n_ptr   = CW'(1);
                        n_pend  = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                raddr = r_ptr[AW-1:0];
                if (r_pend && hit) begin
                    n_removed = 1'b1;
                    // r_ptr-1 is matched entry; its successor is being read now
                    if (r_ptr >= r_count) begin
                        n_count = r_count - 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr + 1'b1;
                        n_pend  = 1'b1;
                        n_state = S_SHIFT;
                    end
                end else if (r_ptr >= r_count) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr  = r_ptr + 1'b1;
                    n_pend = 1'b1;
                end
            end
            S_SHIFT: begin
                // data of entry r_ptr-1 moves to r_ptr-2
                raddr = r_ptr[AW-1:0];
                we    = 1'b1;
                waddr = AW'(r_ptr - CW'(2));
                wx    = r_dx;
                wy    = r_dy;
                if (r_ptr >= r_count) begin
                    n_count = r_count - 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_ptr  = r_ptr + 1'b1;
                    n_pend = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ptr     <= '0;
            r_pend    <= 1'b0;
            r_removed <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ptr     <= n_ptr;
            r_pend    <= n_pend;
            r_removed <= n_removed;
        end
    end

    assign o_rd_x    = r_dx;
    assign o_rd_y    = r_dy;
    assign o_count   = r_count;
    assign o_busy    = (r_state != S_IDLE);
    assign o_removed = r_removed;

endmodule

@@ hw/rtl/point_list_proximity_delete.sv @@
// Point list store with proximity delete. One item is in flight at a time; the next
// item is accepted in the cycle after its predecessor's result beat is taken. Append,
// read and no-op items pass through the WAIT, DONE and OUT states before the result
// is registered. A delete holds in DONE until every bank is idle again, as set by
// the sequential scan and compaction through each list's point memory (one read and
// one write per cycle); all lists run in parallel banks. Tolerance is written through
// i_cfg_we/i_cfg_data; the user must write it while no item is in flight, which
// the block does not enforce. The result stays in an output register until taken.
module point_list_proximity_delete
    import plpd_pkg::*;
#(
    parameter int NUM_LISTS  = NUM_LISTS_DEF,
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [TOL_W-1:0]          i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_action,
    input  logic [LIST_SEL_W-1:0]     i_list_sel,
    input  logic [INDEX_W-1:0]        i_point_index,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [1:0]                o_status,
    output logic [MASK_W-1:0]         o_removed_mask,
    output logic signed [COORD_W-1:0] o_read_x,
    output logic signed [COORD_W-1:0] o_read_y,
    output logic [COUNT_W-1:0]        o_list_count
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS+1);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_WAIT = 4'b0010,
        C_DONE = 4'b0100,
        C_OUT  = 4'b1000
    } t_cstate;

    t_cstate r_state, n_state;
    logic [TOL_W-1:0] r_tol;
    logic [1:0] r_act;
    logic [LIST_SEL_W-1:0] r_sel;
    logic [INDEX_W-1:0] r_idx;
    logic signed [COORD_W-1:0] r_x, r_y;
    logic r_ovalid;
    logic [1:0] r_status;
    logic [MASK_W-1:0] r_mask;
    logic [COORD_W-1:0] r_rx, r_ry;
    logic [COUNT_W-1:0] r_cnt;
    logic r_full;

    logic accept, sel_ok, app_full;
    logic [NUM_LISTS-1:0] busy, removed;
    logic [COORD_W-1:0] bx [NUM_LISTS];
    logic [COORD_W-1:0] by [NUM_LISTS];
    logic [CW-1:0] bc [NUM_LISTS];
    logic [CW-1:0] cnt_sel;
    logic [COORD_W-1:0] x_sel, y_sel;

    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == C_IDLE) && !r_ovalid;
    assign sel_ok = 32'(r_sel) < NUM_LISTS;

    for (genvar l = 0; l < NUM_LISTS; l++) begin : g_bank
        plpd_bank #(.MAX_POINTS(MAX_POINTS)) u_bank (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_start_del (accept && i_action == ACT_DELETE),
            .i_app       (accept && i_action == ACT_APPEND && 32'(i_list_sel) == l),
            .i_rd_addr   (AW'(r_idx)),
            .i_x         (accept ? i_coord_x : r_x),
            .i_y         (accept ? i_coord_y : r_y),
            .i_tol       (r_tol),
            .o_rd_x      (bx[l]),
            .o_rd_y      (by[l]),
            .o_count     (bc[l]),
            .o_busy      (busy[l]),
            .o_removed   (removed[l])
        );
    end

    always_comb begin
        cnt_sel = '0;
        x_sel   = '0;
        y_sel   = '0;
        for (int l = 0; l < NUM_LISTS; l++) begin
            if (32'(r_sel) == l) begin
                cnt_sel = bc[l];
                x_sel   = bx[l];
                y_sel   = by[l];
            end
        end
    end

    // append target full before the beat, or no such list
    always_comb begin
        app_full = 1'b1;
        for (int l = 0; l < NUM_LISTS; l++) begin
            if (32'(i_list_sel) == l) app_full = (bc[l] >= CW'(MAX_POINTS));
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: if (accept) n_state = C_WAIT;
            C_WAIT: n_state = C_DONE;
            C_DONE: if (busy == '0) n_state = C_OUT;
            C_OUT:  n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act  <= i_action;
            r_sel  <= i_list_sel;
            r_idx  <= i_point_index;
            r_x    <= i_coord_x;
            r_y    <= i_coord_y;
            r_full <= app_full;
        end
        if (r_state == C_OUT) begin
            r_status <= ST_OK;
            r_mask   <= '0;
            r_rx     <= '0;
            r_ry     <= '0;
            r_cnt    <= sel_ok ? COUNT_W'(cnt_sel) : '0;
            case (r_act)
                ACT_APPEND: if (!sel_ok || r_full) r_status <= ST_FULL;
                ACT_DELETE: r_mask <= MASK_W'(removed);
                ACT_READ: begin
                    if (!sel_ok || CW'(r_idx) >= cnt_sel || 32'(r_idx) >= MAX_POINTS) begin
                        r_status <= ST_BAD_READ;
                    end else begin
                        r_rx <= x_sel;
                        r_ry <= y_sel;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= C_IDLE;
            r_tol    <= TOL_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_tol <= i_cfg_data;
            if (r_state == C_OUT) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_removed_mask = r_mask;
    assign o_read_x       = r_rx;
    assign o_read_y       = r_ry;
    assign o_list_count   = r_cnt;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> busy == '0) else $error("item accepted while a bank works");
    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_OUT) |-> !r_ovalid) else $error("result overwritten");
    a_ready_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");

endmodule
